FILE: hdl/ptrt_pkg.sv
// Shared types and codes for the periodic task release table.
// Holds command and status codes, the FSM state type and the cell control and status structs.
// No dependencies.
package ptrt_pkg;

  localparam int NUM_TASKS_DEF = 8;
  localparam int MAX_RELEASES = 8;
  localparam int REL_CNT_W = $clog2(MAX_RELEASES + 1);

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_CREATE  = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_SUSPEND = 3'd3;
  localparam logic [2:0] CMD_RESUME  = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RESERVED = 2'd1;
  localparam logic [1:0] STAT_BAD      = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic       create;
    logic       del;
    logic       susp;
    logic       resume;
    logic [7:0] slot;
    logic [7:0] period;
    logic [7:0] delay;
  } ptrt_ctl_t;

  typedef struct packed {
    logic hit_used;
    logic rel;
  } ptrt_stat_t;

endpackage

FILE: hdl/ptrt_cell.sv
// One task slot of the release table: used, running, period and countdown.
// Passes the tick walk token to its neighbor. Depends on ptrt_pkg.
module ptrt_cell import ptrt_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ptrt_ctl_t  ctl,
  input  logic       tok_in,
  output logic       tok_out,
  output ptrt_stat_t stat
);

  logic       used_r, used_nxt;
  logic       run_r, run_nxt;
  logic [7:0] per_r, per_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       tok_r;
  logic       sel;
  logic       active;

  assign sel    = (ctl.slot == 8'(IDX));
  assign active = used_r && run_r;

  always_comb begin
    used_nxt = used_r;
    run_nxt  = run_r;
    per_nxt  = per_r;
    cnt_nxt  = cnt_r;
    if (tok_r && active) begin
      if (cnt_r == 8'd0) begin
        cnt_nxt = per_r;
      end else begin
        cnt_nxt = cnt_r - 8'd1;
      end
    end
    if (sel) begin
      if (ctl.create) begin
        used_nxt = 1'b1;
        run_nxt  = 1'b1;
        per_nxt  = ctl.period;
        cnt_nxt  = ctl.delay;
      end
      if (ctl.del) begin
        used_nxt = 1'b0;
        run_nxt  = 1'b0;
        per_nxt  = 8'd0;
        cnt_nxt  = 8'd0;
      end
      if (ctl.susp) begin
        run_nxt = 1'b0;
      end
      if (ctl.resume) begin
        run_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      run_r  <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      run_r  <= run_nxt;
      tok_r  <= tok_in;
    end
    per_r <= per_nxt;
    cnt_r <= cnt_nxt;
  end

  assign tok_out       = tok_r;
  assign stat.hit_used = used_r && sel;
  assign stat.rel      = tok_r && active && (cnt_r == 8'd0);

endmodule

FILE: hdl/periodic_task_release_table_unit.sv
// Top level of the periodic task release table: command sequencer and cell row.
// Instantiates ptrt_cell once per task slot. Depends on ptrt_pkg.
//
// Usage: present a transaction on in_cmd, in_slot, in_period and in_first_delay
// with start high; it is taken at a rising edge where busy is low. Every command
// other than tick is checked in the S_EXEC state and answers with one result that
// is registered as S_EXEC ends; busy is high during S_EXEC, so a new transaction
// can be taken at the same edge at which that result is accepted.
// A tick passes a token down the row of cells, one slot per cycle, so busy stays
// high through S_WALK and S_FLUSH; the walk length is set by the cell row.
// Releases come out in slot order, each one in the cycle after the next is found. The
// final one, tagged with out_last, is sent from S_FLUSH and is accepted at the
// same edge at which the block can take a new transaction.
// A tick with no release gives one result with out_release_valid low. Each result
// is shown for one cycle with out_strobe high; the receiver cannot stall, so no
// result waits. Reset empties the table and leaves the block idle at once.
module periodic_task_release_table_unit import ptrt_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_slot,
  input  logic [7:0] in_period,
  input  logic [7:0] in_first_delay,
  output logic       out_strobe,
  output logic [1:0] out_status,
  output logic       out_release_valid,
  output logic [2:0] out_released_slot,
  output logic       out_last
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [REL_CNT_W-1:0] rel_cnt_r, rel_cnt_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [2:0]           pend_slot_r, pend_slot_nxt;
  logic [2:0]           cmd_r, cmd_nxt;
  logic [7:0]           slot_r, slot_nxt;
  logic [7:0]           per_r, per_nxt;
  logic [7:0]           dly_r, dly_nxt;
  logic                 strobe_r, strobe_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 relv_r, relv_nxt;
  logic [2:0]           rslot_r, rslot_nxt;
  logic                 last_r, last_nxt;

  ptrt_ctl_t            ctl;
  ptrt_stat_t           stat [NUM_TASKS];
  logic [NUM_TASKS:0]   tok;
  logic                 tok_start;
  logic [NUM_TASKS-1:0] tok_cells;
  logic                 any_used;
  logic                 any_rel;
  logic                 in_range;
  logic [7:0]           idx_ext;

  genvar g;
  generate
    for (g = 0; g < NUM_TASKS; g++) begin : g_cell
      ptrt_cell #(.IDX(g)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .tok_in  (tok[g]),
        .tok_out (tok[g+1]),
        .stat    (stat[g])
      );
    end
  endgenerate

  assign tok[0]    = tok_start;
  assign tok_cells = tok[NUM_TASKS:1];

  always_comb begin
    any_used = 1'b0;
    any_rel  = 1'b0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      any_used = any_used | stat[i].hit_used;
      any_rel  = any_rel | stat[i].rel;
    end
  end

  assign in_range = ({1'b0, slot_r} < 9'(NUM_TASKS));
  assign idx_ext  = 8'(idx_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rel_cnt_nxt   = rel_cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    cmd_nxt       = cmd_r;
    slot_nxt      = slot_r;
    per_nxt       = per_r;
    dly_nxt       = dly_r;
    strobe_nxt    = 1'b0;
    status_nxt    = STAT_OK;
    relv_nxt      = 1'b0;
    rslot_nxt     = 3'd0;
    last_nxt      = 1'b0;
    tok_start     = 1'b0;
    ctl.create    = 1'b0;
    ctl.del       = 1'b0;
    ctl.susp      = 1'b0;
    ctl.resume    = 1'b0;
    ctl.slot      = slot_r;
    ctl.period    = per_r;
    ctl.delay     = dly_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_cmd;
          slot_nxt = in_slot;
          per_nxt  = in_period;
          dly_nxt  = in_first_delay;
          if (in_cmd == CMD_TICK) begin
            tok_start   = 1'b1;
            idx_nxt     = '0;
            rel_cnt_nxt = '0;
            pend_v_nxt  = 1'b0;
            state_nxt   = S_WALK;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        state_nxt  = S_IDLE;
        if (!in_range) begin
          status_nxt = STAT_BAD;
        end else begin
          case (cmd_r)
            CMD_CREATE: begin
              if (any_used) begin
                status_nxt = STAT_RESERVED;
              end else begin
                ctl.create = 1'b1;
              end
            end
            CMD_DELETE: begin
              if (any_used) ctl.del = 1'b1;
              else status_nxt = STAT_BAD;
            end
            CMD_SUSPEND: begin
              if (any_used) ctl.susp = 1'b1;
              else status_nxt = STAT_BAD;
            end
            CMD_RESUME: begin
              if (any_used) ctl.resume = 1'b1;
              else status_nxt = STAT_BAD;
            end
            default: begin
              status_nxt = STAT_BAD;
            end
          endcase
        end
      end
      S_WALK: begin
        if (any_rel && (rel_cnt_r < REL_CNT_W'(MAX_RELEASES))) begin
          if (pend_v_r) begin
            strobe_nxt = 1'b1;
            relv_nxt   = 1'b1;
            rslot_nxt  = pend_slot_r;
          end
          pend_v_nxt    = 1'b1;
          pend_slot_nxt = idx_ext[2:0];
          rel_cnt_nxt   = rel_cnt_r + REL_CNT_W'(1);
        end
        if (idx_r == IDX_W'(NUM_TASKS - 1)) begin
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_FLUSH: begin
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        relv_nxt   = pend_v_r;
        rslot_nxt  = pend_v_r ? pend_slot_r : 3'd0;
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_v_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      strobe_r <= strobe_nxt;
    end
    idx_r       <= idx_nxt;
    rel_cnt_r   <= rel_cnt_nxt;
    pend_slot_r <= pend_slot_nxt;
    cmd_r       <= cmd_nxt;
    slot_r      <= slot_nxt;
    per_r       <= per_nxt;
    dly_r       <= dly_nxt;
    status_r    <= status_nxt;
    relv_r      <= relv_nxt;
    rslot_r     <= rslot_nxt;
    last_r      <= last_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_release_valid = relv_r;
  assign out_released_slot = rslot_r;
  assign out_last          = last_r;

  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_cells) <= 1)
    else $error("More than one cell holds the walk token.");

  a_tok_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_WALK) |-> (tok_cells == '0))
    else $error("Walk token present outside a tick walk.");

  a_tok_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> tok_cells[idx_r])
    else $error("Walk token is not at the slot being scanned.");

  a_rel_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |=> (rel_cnt_r <= REL_CNT_W'(MAX_RELEASES)))
    else $error("Release count passed its limit.");

  a_rel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_release_valid) |-> (out_status == STAT_OK))
    else $error("Release reported with a failing status.");

endmodule

FILE: test/tb_periodic_task_release_table_unit.sv
// Self-checking testbench for periodic_task_release_table_unit: directed and random commands.
// Keeps its own copy of the task slot table to predict every result.
// Depends on ptrt_pkg and the unit's RTL.
module tb_periodic_task_release_table_unit;
  import ptrt_pkg::*;

  localparam int NTASK = NUM_TASKS_DEF;
  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 360;

  typedef struct packed {
    logic [1:0] status;
    logic       rel;
    logic [2:0] slot;
    logic       is_last;
  } answer_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_cmd = 3'd0;
  logic [7:0] in_slot = 8'd0;
  logic [7:0] in_period = 8'd0;
  logic [7:0] in_first_delay = 8'd0;
  logic       out_strobe;
  logic [1:0] out_status;
  logic       out_release_valid;
  logic [2:0] out_released_slot;
  logic       out_last;

  bit       held [NTASK];
  bit       live [NTASK];
  bit [7:0] reload_val [NTASK];
  bit [7:0] countdown [NTASK];

  answer_t due_answers [$];
  int      errors = 0;
  int      cycles = 0;
  int      n_sent = 0;
  int      n_releases = 0;
  int      n_reserved = 0;
  int      n_rejected = 0;
  bit      no_gap = 1'b0;

  periodic_task_release_table_unit #(.NUM_TASKS(NTASK)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_slot(in_slot),
    .in_period(in_period),
    .in_first_delay(in_first_delay),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_release_valid(out_release_valid),
    .out_released_slot(out_released_slot),
    .out_last(out_last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_answers.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic step_task_table(input logic [2:0] c, input logic [7:0] s,
                                 input logic [7:0] p, input logic [7:0] d);
    int      n;
    answer_t a;
    logic [1:0] st;
    n = 0;
    st = STAT_OK;
    if (c == CMD_TICK) begin
      for (int i = 0; i < NTASK; i++) begin
        if (held[i] && live[i]) begin
          if (countdown[i] == 8'd0) begin
            a = '{STAT_OK, 1'b1, 3'(i), 1'b0};
            due_answers.push_back(a);
            n++;
            countdown[i] = reload_val[i];
          end else begin
            countdown[i] = countdown[i] - 8'd1;
          end
        end
      end
      if (n == 0) begin
        a = '{STAT_OK, 1'b0, 3'd0, 1'b1};
        due_answers.push_back(a);
      end else begin
        a = due_answers.pop_back();
        a.is_last = 1'b1;
        due_answers.push_back(a);
      end
    end else begin
      if (c > CMD_RESUME || s >= NTASK) begin
        st = STAT_BAD;
      end else if (c == CMD_CREATE) begin
        if (held[s]) begin
          st = STAT_RESERVED;
        end else begin
          held[s] = 1'b1;
          live[s] = 1'b1;
          reload_val[s] = p;
          countdown[s] = d;
        end
      end else if (!held[s]) begin
        st = STAT_BAD;
      end else if (c == CMD_DELETE) begin
        held[s] = 1'b0;
        live[s] = 1'b0;
        reload_val[s] = 8'd0;
        countdown[s] = 8'd0;
      end else if (c == CMD_SUSPEND) begin
        live[s] = 1'b0;
      end else begin
        live[s] = 1'b1;
      end
      a = '{st, 1'b0, 3'd0, 1'b1};
      due_answers.push_back(a);
    end
  endtask

  // Called at a rising edge; returns at the edge that accepts the transaction.
  task automatic send(input logic [2:0] c, input logic [7:0] s,
                      input logic [7:0] p, input logic [7:0] d);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= c;
    in_slot <= s;
    in_period <= p;
    in_first_delay <= d;
    do @(posedge clk); while (busy);
    n_sent++;
    step_task_table(c, s, p, d);
  endtask

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_answers
    answer_t want;
    if (rst_n && out_strobe) begin
      if (out_release_valid === 1'b1) n_releases++;
      if (out_status === STAT_RESERVED) n_reserved++;
      if (out_status === STAT_BAD) n_rejected++;
      if (due_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d rel %0d",
                 $time, out_status, out_release_valid);
        $display("%0t: unexpected result, actual slot %0d last %0d",
                 $time, out_released_slot, out_last);
      end else begin
        want = due_answers.pop_front();
        check_field("status", 8'(want.status), 8'(out_status));
        check_field("release_valid", 8'(want.rel), 8'(out_release_valid));
        check_field("released_slot", 8'(want.slot), 8'(out_released_slot));
        check_field("last", 8'(want.is_last), 8'(out_last));
      end
    end
  end

  task automatic test_bad_requests();
    no_gap = 1'b1;
    send(CMD_CREATE, 8'd8, 8'd3, 8'd3);
    send(CMD_CREATE, 8'd255, 8'd255, 8'd255);
    send(CMD_SUSPEND, 8'd5, 8'd0, 8'd0);
    for (int c = int'(CMD_RESUME) + 1; c < 8; c++) begin
      send(3'(c), 8'd0, 8'd255, 8'd255);
    end
    send(CMD_TICK, 8'd255, 8'd255, 8'd255);
  endtask

  task automatic test_slot_lifecycle();
    no_gap = 1'b0;
    for (int i = 0; i < NTASK; i++) begin
      send(CMD_CREATE, 8'(i), (i == NTASK - 1) ? 8'd255 : 8'd0,
           (i == NTASK - 1) ? 8'd1 : 8'd0);
    end
    send(CMD_CREATE, 8'd0, 8'd7, 8'd7);
    send(CMD_TICK, 8'd0, 8'd0, 8'd0);
    send(CMD_TICK, 8'd0, 8'd0, 8'd0);
    send(CMD_SUSPEND, 8'd3, 8'd0, 8'd0);
    send(CMD_TICK, 8'd0, 8'd0, 8'd0);
    send(CMD_RESUME, 8'd3, 8'd0, 8'd0);
    send(CMD_DELETE, 8'(NTASK - 1), 8'd0, 8'd0);
    send(CMD_DELETE, 8'(NTASK - 1), 8'd0, 8'd0);
    send(CMD_RESUME, 8'(NTASK - 1), 8'd0, 8'd0);
  endtask

  task automatic test_random_traffic();
    logic [2:0] c;
    logic [7:0] s;
    logic [7:0] p;
    logic [7:0] d;
    int         r;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 24 == 0) no_gap = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 40) c = CMD_TICK;
      else if (r < 55) c = CMD_CREATE;
      else if (r < 70) c = CMD_DELETE;
      else if (r < 80) c = CMD_SUSPEND;
      else if (r < 93) c = CMD_RESUME;
      else c = 3'(CMD_RESUME + $urandom_range(1, 3));
      s = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, NTASK - 1))
                                       : 8'($urandom_range(NTASK, 255));
      p = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4));
      d = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4));
      send(c, s, p, d);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bad_requests();
    test_slot_lifecycle();
    test_random_traffic();
    start <= 1'b0;
    while (due_answers.size() != 0) @(posedge clk);
    repeat (NTASK + 4) @(posedge clk);
    $display("Sent %0d transactions; saw %0d task releases, %0d reserved and %0d rejected.",
             n_sent, n_releases, n_reserved, n_rejected);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
